// ----- hw/rtl/rrts_pkg.sv -----
// Shared types and constants for the round-robin task scheduler.
package rrts_pkg;

   localparam int ID_W = 6;
   localparam int NUM_TASKS_DEF = 32;
   localparam int QUANTUM_W = 16;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd20;
   localparam logic [ID_W-1:0] REF_MAX = 6'd63;
   localparam logic [ID_W-1:0] ROOT_TASK = 6'd1;

   localparam logic [2:0] OPC_CREATE = 3'd0;
   localparam logic [2:0] OPC_RESUME = 3'd1;
   localparam logic [2:0] OPC_BLOCK = 3'd2;
   localparam logic [2:0] OPC_SWITCH = 3'd3;
   localparam logic [2:0] OPC_DESTROY = 3'd4;

   localparam logic [2:0] RC_OK = 3'd0;
   localparam logic [2:0] RC_TOO_MANY = 3'd1;
   localparam logic [2:0] RC_INVALID = 3'd2;
   localparam logic [2:0] RC_REFERENCED = 3'd3;
   localparam logic [2:0] RC_WRONG_STATE = 3'd4;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_RESUME,
      OP_BLOCK,
      OP_SWITCH,
      OP_DESTROY,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [ID_W-1:0] task_id;
      logic [ID_W-1:0] pager_id;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [ID_W-1:0] new_task_id;
      logic [ID_W-1:0] running_task;
      logic switched;
      logic [QUANTUM_W-1:0] quantum_grant;
   } rsp_type;

   typedef struct packed {
      op_type op;
      logic [ID_W-1:0] task_id;
      logic [ID_W-1:0] pager_id;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_CR_INC,
      BK_CR_LINK,
      BK_DS_REF,
      BK_DS_STEP,
      BK_DS_FREE,
      BK_DS_DEC
   } back_state_type;

endpackage

// ----- hw/rtl/rrts_front.sv -----
// Command intake: decodes request words and queues them for the back end.
module rrts_front import rrts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   input  logic    pop,
   output logic    cmd_valid,
   output cmd_type cmd
);

   cmd_type    slot_ff [2];
   cmd_type    slot_in [2];
   logic [1:0] count_ff, count_in;
   cmd_type    dec;
   logic       push;

   always_comb begin
      dec.task_id = req_data.task_id;
      dec.pager_id = req_data.pager_id;
      unique case (req_data.opcode)
         OPC_CREATE:  dec.op = OP_CREATE;
         OPC_RESUME:  dec.op = OP_RESUME;
         OPC_BLOCK:   dec.op = OP_BLOCK;
         OPC_SWITCH:  dec.op = OP_SWITCH;
         OPC_DESTROY: dec.op = OP_DESTROY;
         default:     dec.op = OP_BAD;
      endcase
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd = slot_ff[0];

   always_comb begin
      slot_in = slot_ff;
      count_in = count_ff;
      if (pop && cmd_valid) begin
         slot_in[0] = slot_ff[1];
         count_in = count_in - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = dec;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/rrts_back.sv -----
// Command execution: task table, run queue, reference counts and current task.
module rrts_back import rrts_pkg::*; #(
   parameter int NUM_TASKS = NUM_TASKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  cmd_type              cmd,
   output logic                 pop,
   input  logic [QUANTUM_W-1:0] quantum,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data
);

   localparam int IW = $clog2(NUM_TASKS + 1);
   localparam int DEPTH = 1 << IW;
   localparam logic [ID_W-1:0] NT = ID_W'(NUM_TASKS);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [DEPTH-1:0] used_ff, used_in, run_ff, run_in, inq_ff, inq_in;
   logic [ID_W-1:0] head_ff, head_in, tail_ff, tail_in, count_ff, count_in;
   logic [ID_W-1:0] cur_ff, cur_in;
   logic [ID_W-1:0] alloc_ff, alloc_in, pgr_ff, pgr_in;
   logic [ID_W-1:0] at_ff, at_in, prev_ff, prev_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   rsp_type         rsp_ff, rsp_in;

   logic [ID_W-1:0] link_mem [DEPTH];
   logic [ID_W-1:0] ref_mem [DEPTH];
   logic [ID_W-1:0] pager_mem [DEPTH];
   logic [ID_W-1:0] link_rd_ff, ref_rd_ff, pager_rd_ff;
   logic            link_we, ref_we, pager_we;
   logic [IW-1:0]   link_wa, ref_wa, pager_wa, link_ra, ref_ra, pager_ra;
   logic [ID_W-1:0] link_wd, ref_wd, pager_wd;

   logic [ID_W-1:0] free_id;
   logic [ID_W-1:0] tid, pid, nxt, popped;
   logic            tid_ok, pid_ok, prev_run, enq_req, finish;
   logic [ID_W-1:0] enq_id;
   logic [2:0]      status;
   logic            sw;
   logic [QUANTUM_W-1:0] grant;
   logic [ID_W-1:0] new_id;

   always_comb begin
      free_id = '0;
      for (int i = NUM_TASKS; i >= 1; i--) begin
         if (!used_ff[i]) begin
            free_id = ID_W'(i);
         end
      end
   end

   assign tid = cmd_ff.task_id;
   assign pid = cmd_ff.pager_id;
   assign tid_ok = (tid != '0) && (tid <= NT) && used_ff[tid[IW-1:0]];
   assign pid_ok = (pid != '0) && (pid <= NT) && used_ff[pid[IW-1:0]];
   assign prev_run = (cur_ff != '0) && used_ff[cur_ff[IW-1:0]] && run_ff[cur_ff[IW-1:0]];

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      used_in = used_ff;
      run_in = run_ff;
      inq_in = inq_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      cur_in = cur_ff;
      alloc_in = alloc_ff;
      pgr_in = pgr_ff;
      at_in = at_ff;
      prev_in = prev_ff;
      pop = 1'b0;
      link_we = 1'b0;
      ref_we = 1'b0;
      pager_we = 1'b0;
      link_wa = '0;
      ref_wa = '0;
      pager_wa = '0;
      link_wd = '0;
      ref_wd = '0;
      pager_wd = '0;
      link_ra = head_ff[IW-1:0];
      ref_ra = tid[IW-1:0];
      pager_ra = tid[IW-1:0];
      enq_req = 1'b0;
      enq_id = '0;
      finish = 1'b0;
      status = RC_OK;
      sw = 1'b0;
      grant = '0;
      new_id = '0;
      nxt = '0;
      popped = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               pop = 1'b1;
               cmd_in = cmd;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            unique case (cmd_ff.op)
               OP_CREATE: begin
                  if (pid != '0 && !pid_ok) begin
                     status = RC_INVALID;
                     finish = 1'b1;
                  end else if (free_id == '0) begin
                     status = RC_TOO_MANY;
                     finish = 1'b1;
                  end else begin
                     pager_we = 1'b1;
                     pager_wa = free_id[IW-1:0];
                     pager_wd = pid;
                     ref_ra = pid[IW-1:0];
                     alloc_in = free_id;
                     state_in = BK_CR_INC;
                  end
               end
               OP_RESUME: begin
                  finish = 1'b1;
                  if (!tid_ok) begin
                     status = RC_INVALID;
                  end else if (run_ff[tid[IW-1:0]]) begin
                     status = RC_WRONG_STATE;
                  end else begin
                     run_in[tid[IW-1:0]] = 1'b1;
                     enq_req = !inq_ff[tid[IW-1:0]];
                     enq_id = tid;
                  end
               end
               OP_BLOCK: begin
                  finish = 1'b1;
                  if (!tid_ok) begin
                     status = RC_INVALID;
                  end else if (!run_ff[tid[IW-1:0]]) begin
                     status = RC_WRONG_STATE;
                  end else begin
                     run_in[tid[IW-1:0]] = 1'b0;
                  end
               end
               OP_SWITCH: begin
                  link_ra = head_ff[IW-1:0];
                  state_in = BK_CR_LINK;
                  alloc_in = '0;
               end
               OP_DESTROY: begin
                  if (!tid_ok) begin
                     status = RC_INVALID;
                     finish = 1'b1;
                  end else if (tid == cur_ff) begin
                     status = RC_WRONG_STATE;
                     finish = 1'b1;
                  end else if (tid == ROOT_TASK) begin
                     status = RC_INVALID;
                     finish = 1'b1;
                  end else begin
                     state_in = BK_DS_REF;
                  end
               end
               default: begin
                  status = RC_INVALID;
                  finish = 1'b1;
               end
            endcase
         end
         BK_CR_INC: begin
            if (pid != '0) begin
               ref_we = 1'b1;
               ref_wa = pid[IW-1:0];
               ref_wd = (ref_rd_ff < REF_MAX) ? ref_rd_ff + 1'b1 : ref_rd_ff;
            end
            state_in = BK_CR_LINK;
         end
         BK_CR_LINK: begin
            finish = 1'b1;
            if (cmd_ff.op == OP_SWITCH) begin
               if (count_ff != '0) begin
                  popped = head_ff;
                  nxt = head_ff;
                  head_in = link_rd_ff;
                  count_in = count_ff - 1'b1;
                  inq_in[head_ff[IW-1:0]] = 1'b0;
                  if (count_in == '0) begin
                     head_in = '0;
                     tail_in = '0;
                  end
               end
               if (nxt == '0 && prev_run) begin
                  nxt = cur_ff;
               end
               if (nxt != '0) begin
                  grant = quantum;
               end
               if (nxt != cur_ff) begin
                  sw = 1'b1;
                  cur_in = nxt;
                  enq_req = prev_run &&
                            !(inq_ff[cur_ff[IW-1:0]] && popped != cur_ff);
                  enq_id = cur_ff;
               end
            end else begin
               ref_we = 1'b1;
               ref_wa = alloc_ff[IW-1:0];
               ref_wd = '0;
               used_in[alloc_ff[IW-1:0]] = 1'b1;
               run_in[alloc_ff[IW-1:0]] = 1'b1;
               enq_req = 1'b1;
               enq_id = alloc_ff;
               new_id = alloc_ff;
            end
         end
         BK_DS_REF: begin
            pgr_in = pager_rd_ff;
            if (ref_rd_ff != '0) begin
               status = RC_REFERENCED;
               finish = 1'b1;
            end else if (inq_ff[tid[IW-1:0]]) begin
               at_in = head_ff;
               prev_in = '0;
               link_ra = head_ff[IW-1:0];
               state_in = BK_DS_STEP;
            end else begin
               state_in = BK_DS_FREE;
            end
         end
         BK_DS_STEP: begin
            if (at_ff == tid) begin
               if (prev_ff == '0) begin
                  head_in = link_rd_ff;
               end else begin
                  link_we = 1'b1;
                  link_wa = prev_ff[IW-1:0];
                  link_wd = link_rd_ff;
               end
               if (tail_ff == tid) begin
                  tail_in = prev_ff;
               end
               count_in = count_ff - 1'b1;
               if (count_in == '0) begin
                  head_in = '0;
                  tail_in = '0;
               end
               inq_in[tid[IW-1:0]] = 1'b0;
               state_in = BK_DS_FREE;
            end else begin
               prev_in = at_ff;
               at_in = link_rd_ff;
               link_ra = link_rd_ff[IW-1:0];
            end
         end
         BK_DS_FREE: begin
            used_in[tid[IW-1:0]] = 1'b0;
            run_in[tid[IW-1:0]] = 1'b0;
            ref_ra = pgr_ff[IW-1:0];
            state_in = BK_DS_DEC;
         end
         BK_DS_DEC: begin
            finish = 1'b1;
            if (pgr_ff != '0 && pgr_ff <= NT && ref_rd_ff != '0) begin
               ref_we = 1'b1;
               ref_wa = pgr_ff[IW-1:0];
               ref_wd = ref_rd_ff - 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      if (enq_req && count_in < NT) begin
         if (count_in == '0) begin
            head_in = enq_id;
         end else begin
            link_we = 1'b1;
            link_wa = tail_in[IW-1:0];
            link_wd = enq_id;
         end
         tail_in = enq_id;
         count_in = count_in + 1'b1;
         inq_in[enq_id[IW-1:0]] = 1'b1;
      end
      if (finish) begin
         state_in = BK_IDLE;
      end
      rsp_strobe_in = finish;
      rsp_in.status = status;
      rsp_in.new_task_id = new_id;
      rsp_in.running_task = cur_in;
      rsp_in.switched = sw;
      rsp_in.quantum_grant = grant;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (ref_we) begin
         ref_mem[ref_wa] <= ref_wd;
      end
      if (pager_we) begin
         pager_mem[pager_wa] <= pager_wd;
      end
      link_rd_ff <= link_mem[link_ra];
      ref_rd_ff <= ref_mem[ref_ra];
      pager_rd_ff <= pager_mem[pager_ra];
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      alloc_ff <= alloc_in;
      pgr_ff <= pgr_in;
      at_ff <= at_in;
      prev_ff <= prev_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= BK_IDLE;
         used_ff <= '0;
         run_ff <= '0;
         inq_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         cur_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         run_ff <= run_in;
         inq_ff <= inq_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         cur_ff <= cur_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

endmodule

// ----- hw/rtl/round_robin_task_scheduler_core.sv -----
// Each command is taken from the command queue by the back end, executed and answered with
// a response strobe. Create steps through reference-count and link states, switch through
// the link state, and destroy may walk the run-queue links. The back end runs one command
// at a time, so it takes a new command only once the previous one has finished.
// A two-word command queue lets start be taken while a command executes; busy when full.
// Synchronous reset: all tasks unused, run queue empty, idle task running, quantum 20.
module round_robin_task_scheduler_core import rrts_pkg::*; #(
   parameter int NUM_TASKS = NUM_TASKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [QUANTUM_W-1:0] csr_wdata
);

   logic [QUANTUM_W-1:0] quantum_ff;
   logic                 pop, cmd_valid;
   cmd_type              cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_valid) begin
         quantum_ff <= csr_wdata;
      end
   end

   rrts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .pop       (pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   rrts_back #(
      .NUM_TASKS (NUM_TASKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .pop        (pop),
      .quantum    (quantum_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
